[rtl/core/asfx_pkg.sv]
// types and constants shared by the add/subtract execute unit
package asfx_pkg;

   localparam int XLEN      = 64;
   localparam int NUM_REGS  = 32;
   localparam int REG_AW    = 5;

   localparam logic [1:0] OP_EXEC  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_CLASS = 2'd1;
   localparam logic [1:0] STAT_SHIFT = 2'd2;

   localparam logic [4:0] CLS_IMM = 5'd17;
   localparam logic [4:0] CLS_REG = 5'd11;

   localparam logic [1:0] SH_LSL = 2'd0;
   localparam logic [1:0] SH_LSR = 2'd1;
   localparam logic [1:0] SH_ASR = 2'd2;
   localparam logic [1:0] SH_RSV = 2'd3;

   localparam logic [REG_AW-1:0] REG_ZR = 5'd31;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [31:0]       instruction;
      logic [REG_AW-1:0] reg_index;
      logic [XLEN-1:0]   write_data;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              wrote_register;
      logic [REG_AW-1:0] dest_index;
      logic [XLEN-1:0]   result_data;
      logic              flag_n;
      logic              flag_z;
      logic              flag_c;
      logic              flag_v;
   } rsp_type;

endpackage

[rtl/core/armv8_add_sub_flags_execute.sv]
// add/subtract execute unit with register file copies, flags and result register
// request and register reads are registered on acceptance, the result register on commit
// a new request is accepted only in the idle state, once the previous one has committed
// a pending result holds the next request in the execute step, and with it the input
// reset clears the flags and the per-register valid bits, so every register reads as zero
// until written; no clearing pass is needed
module armv8_add_sub_flags_execute
   import asfx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [3:0]        flags_ff, flags_in;
   logic [NUM_REGS-1:0] valid_ff, valid_in;

   logic              accept, commit;
   logic [REG_AW-1:0] rd_addr_a, rd_addr_b;
   logic [XLEN-1:0]   ram_a_data, ram_b_data;
   logic [XLEN-1:0]   reg_a, reg_b;

   logic              wr_en;
   logic [REG_AW-1:0] wr_addr;
   logic [XLEN-1:0]   wr_data;

   logic [31:0]       ir;
   logic              wide, sub, setf, imm_form, do_write, reserved;
   logic [4:0]        cls;
   logic [1:0]        shf;
   logic [11:0]       imm12;
   logic [5:0]        imm6;
   logic [REG_AW-1:0] rm, rn, rd, port_a_idx;
   logic [XLEN-1:0]   imm_b, b_src, b_sh, opa, opb, opb_x, res;
   logic [31:0]       b32, b32_sh;
   logic [XLEN:0]     sum64;
   logic [32:0]       sum32;
   logic              fn, fz, fc, fv;
   logic [3:0]        step_flags;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign commit    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   assign rd_addr_a = (req_data.opcode == OP_EXEC) ? req_data.instruction[9:5]
                                                    : req_data.reg_index;
   assign rd_addr_b = req_data.instruction[20:16];

   asfx_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr_a),
      .rd_data (ram_a_data)
   );

   asfx_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr_b),
      .rd_data (ram_b_data)
   );

   // decode of the held request
   always_comb begin
      ir       = req_ff.instruction;
      wide     = ir[31];
      sub      = ir[30];
      setf     = ir[29];
      cls      = ir[28:24];
      shf      = ir[23:22];
      imm12    = ir[21:10];
      imm6     = ir[15:10];
      rm       = ir[20:16];
      rn       = ir[9:5];
      rd       = ir[4:0];
      imm_form = (cls == CLS_IMM);
      port_a_idx = (req_ff.opcode == OP_EXEC) ? rn : req_ff.reg_index;
      reg_a    = valid_ff[port_a_idx] ? ram_a_data : '0;
      reg_b    = valid_ff[rm] ? ram_b_data : '0;
      if (imm_form) begin
         reserved = shf[1];
         do_write = (rd != REG_ZR) || !setf;
      end else begin
         reserved = (shf == SH_RSV) || (!wide && imm6[5]);
         do_write = (rd != REG_ZR);
      end
   end

   // operand shift and adder
   always_comb begin
      imm_b = (shf == SH_LSR) ? {40'd0, imm12, 12'd0} : {52'd0, imm12};
      b_src = (rm == REG_ZR) ? '0 : reg_b;
      b32   = b_src[31:0];
      b32_sh = b32;
      b_sh   = b_src;
      if (wide) begin
         case (shf)
            SH_LSL:  b_sh = b_src << imm6;
            SH_LSR:  b_sh = b_src >> imm6;
            SH_ASR:  b_sh = $unsigned($signed(b_src) >>> imm6);
            default: b_sh = b_src;
         endcase
      end else begin
         case (shf)
            SH_LSL:  b32_sh = b32 << imm6[4:0];
            SH_LSR:  b32_sh = b32 >> imm6[4:0];
            SH_ASR:  b32_sh = $unsigned($signed(b32) >>> imm6[4:0]);
            default: b32_sh = b32;
         endcase
         b_sh = {32'd0, b32_sh};
      end
      opa   = (!imm_form && (rn == REG_ZR)) ? '0 : reg_a;
      opb   = imm_form ? imm_b : b_sh;
      opb_x = sub ? ~opb : opb;
      sum64 = {1'b0, opa} + {1'b0, opb_x} + {{XLEN{1'b0}}, sub};
      sum32 = {1'b0, opa[31:0]} + {1'b0, opb_x[31:0]} + {32'd0, sub};
      if (wide) begin
         res = sum64[XLEN-1:0];
         fc  = sum64[XLEN];
         fv  = (opa[63] ^ res[63]) & (opb_x[63] ^ res[63]);
         fn  = res[63];
      end else begin
         res = {32'd0, sum32[31:0]};
         fc  = sum32[32];
         fv  = (opa[31] ^ res[31]) & (opb_x[31] ^ res[31]);
         fn  = res[31];
      end
      fz = (res == '0);
      step_flags = {fn, fz, fc, fv};
   end

   // result and write-back selection
   always_comb begin
      rsp_in                = '0;
      rsp_in.status         = STAT_DONE;
      rsp_in.dest_index     = req_ff.reg_index;
      wr_en                 = 1'b0;
      wr_addr               = req_ff.reg_index;
      wr_data               = req_ff.write_data;
      flags_in              = flags_ff;
      case (req_ff.opcode)
         OP_EXEC: begin
            rsp_in.dest_index = rd;
            if (cls != CLS_IMM && cls != CLS_REG) begin
               rsp_in.status = STAT_CLASS;
            end else if (reserved) begin
               rsp_in.status = STAT_SHIFT;
            end else begin
               rsp_in.result_data    = res;
               rsp_in.wrote_register = do_write;
               wr_en                 = commit && do_write;
               wr_addr               = rd;
               wr_data               = res;
               if (setf && commit) begin
                  flags_in = step_flags;
               end
            end
         end
         OP_WRITE: begin
            rsp_in.wrote_register = 1'b1;
            rsp_in.result_data    = req_ff.write_data;
            wr_en                 = commit;
         end
         OP_READ: begin
            rsp_in.result_data = reg_a;
         end
         default: begin
            rsp_in.status = STAT_CLASS;
         end
      endcase
      rsp_in.flag_n = flags_in[3];
      rsp_in.flag_z = flags_in[2];
      rsp_in.flag_c = flags_in[1];
      rsp_in.flag_v = flags_in[0];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = commit ? 1'b1 : (rsp_valid_ff && !rsp_ready);
      valid_in     = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         flags_ff     <= flags_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted request did not enter execute");

   a_write_only_on_commit: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready))
      else $error("register write outside commit");

   a_commit_gives_result: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("commit did not present a result");

   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      !commit |=> (flags_ff == $past(flags_ff)))
      else $error("flags changed without a commit");

   a_written_reg_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(wr_addr)])
      else $error("written register not marked valid");

endmodule

[rtl/core/asfx_ram.sv]
// generic single-write, single-read ram with registered read data
module asfx_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// self-checking bench for the add/subtract execute unit: directed, random and backpressure runs
module tb;
   import asfx_pkg::*;

   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 160;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic [XLEN-1:0] arch_regs [NUM_REGS];
   logic [3:0]      arch_nzcv;
   rsp_type         pending_responses [$];

   int send_idle_pct;
   int recv_stall_pct;
   int hold_length;
   int hold_serial;
   int hold_seen;
   int hold_left;
   int cycle_count;
   int mismatch_count;
   int requests_sent;
   int responses_checked;
   int exec_done;
   int exec_class;
   int exec_shift;

   armv8_add_sub_flags_execute DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] imm_insn(input logic sf, op, s, input logic [1:0] shf,
                                            input logic [11:0] imm12,
                                            input logic [4:0] rn, rd);
      return {sf, op, s, CLS_IMM, shf, imm12, rn, rd};
   endfunction

   function automatic logic [31:0] reg_insn(input logic sf, op, s, input logic [1:0] shf,
                                            input logic x21, input logic [4:0] rm,
                                            input logic [5:0] imm6,
                                            input logic [4:0] rn, rd);
      return {sf, op, s, CLS_REG, shf, x21, rm, imm6, rn, rd};
   endfunction

   // architectural state update and expected response for one request
   function automatic rsp_type execute_request(req_type rq);
      rsp_type         rs;
      logic            wide, sub, setf, do_write, c, v, n, z;
      logic [4:0]      cls, rm, rn, rd;
      logic [1:0]      shf;
      logic [11:0]     imm12;
      logic [5:0]      imm6;
      logic [XLEN-1:0] a, b, r;
      logic [31:0]     a32, b32;
      logic [XLEN:0]   sum;
      logic [32:0]     sum32;
      rs = '0;
      rs.dest_index = rq.reg_index;
      case (rq.opcode)
         OP_WRITE: begin
            arch_regs[rq.reg_index] = rq.write_data;
            rs.wrote_register = 1'b1;
            rs.result_data = rq.write_data;
         end
         OP_READ: begin
            rs.result_data = arch_regs[rq.reg_index];
         end
         OP_SPARE: begin
            rs.status = STAT_CLASS;
         end
         default: begin
            {wide, sub, setf, cls, shf} = rq.instruction[31:22];
            imm12 = rq.instruction[21:10];
            rm = rq.instruction[20:16];
            imm6 = rq.instruction[15:10];
            rn = rq.instruction[9:5];
            rd = rq.instruction[4:0];
            rs.dest_index = rd;
            if (cls != CLS_IMM && cls != CLS_REG) begin
               rs.status = STAT_CLASS;
               exec_class++;
            end else if ((cls == CLS_IMM && shf[1]) ||
                         (cls == CLS_REG && (shf == SH_RSV || (!wide && imm6[5])))) begin
               rs.status = STAT_SHIFT;
               exec_shift++;
            end else begin
               if (cls == CLS_IMM) begin
                  // sp is a real register here
                  a = arch_regs[rn];
                  b = {52'b0, imm12} << (shf[0] ? 12 : 0);
                  do_write = (rd != REG_ZR) || !setf;
               end else begin
                  a = (rn == REG_ZR) ? '0 : arch_regs[rn];
                  b = (rm == REG_ZR) ? '0 : arch_regs[rm];
                  b32 = b[31:0];
                  if (wide) begin
                     case (shf)
                        SH_LSL:  b = b << imm6;
                        SH_LSR:  b = b >> imm6;
                        default: b = $signed(b) >>> imm6;
                     endcase
                  end else begin
                     case (shf)
                        SH_LSL:  b = {32'b0, b32 << imm6};
                        SH_LSR:  b = {32'b0, b32 >> imm6};
                        default: b = {32'b0, $signed(b32) >>> imm6};
                     endcase
                  end
                  do_write = (rd != REG_ZR);
               end
               if (sub) begin
                  b = ~b;
               end
               if (wide) begin
                  sum = {1'b0, a} + {1'b0, b} + {{XLEN{1'b0}}, sub};
                  r = sum[XLEN-1:0];
                  c = sum[XLEN];
                  v = (a[XLEN-1] ^ r[XLEN-1]) & (b[XLEN-1] ^ r[XLEN-1]);
                  n = r[XLEN-1];
               end else begin
                  a32 = a[31:0];
                  b32 = b[31:0];
                  sum32 = {1'b0, a32} + {1'b0, b32} + {32'b0, sub};
                  r = {32'b0, sum32[31:0]};
                  c = sum32[32];
                  v = (a32[31] ^ r[31]) & (b32[31] ^ r[31]);
                  n = r[31];
               end
               z = (r == '0);
               if (setf) begin
                  arch_nzcv = {n, z, c, v};
               end
               if (do_write) begin
                  arch_regs[rd] = r;
               end
               rs.wrote_register = do_write;
               rs.result_data = r;
               exec_done++;
            end
         end
      endcase
      {rs.flag_n, rs.flag_z, rs.flag_c, rs.flag_v} = arch_nzcv;
      return rs;
   endfunction

   task automatic send_request(req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      pending_responses.push_back(execute_request(item));
      requests_sent++;
   endtask

   task automatic write_register(logic [4:0] idx, logic [XLEN-1:0] value);
      send_request('{OP_WRITE, $urandom, idx, value});
   endtask

   task automatic read_register(logic [4:0] idx);
      send_request('{OP_READ, $urandom, idx, {$urandom, $urandom}});
   endtask

   task automatic run_instruction(logic [31:0] insn);
      send_request('{OP_EXEC, insn, 5'($urandom), {$urandom, $urandom}});
   endtask

   function automatic logic [4:0] pick_register();
      int p;
      p = $urandom_range(99);
      if (p < 15) return REG_ZR;
      if (p < 75) return 5'($urandom_range(0, 7));
      return 5'($urandom);
   endfunction

   function automatic logic [XLEN-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         2:       return 64'd1;
         3:       return 64'h8000_0000_0000_0000;
         4:       return 64'h7fff_ffff_ffff_ffff;
         5:       return 64'h0000_0000_ffff_ffff;
         6:       return 64'h0000_0000_8000_0000;
         7:       return 64'h0000_0000_7fff_ffff;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_type random_request();
      req_type    rq;
      int         pick;
      logic       sf;
      logic [1:0] shf;
      logic [5:0] imm6;
      rq = '{OP_EXEC, $urandom, 5'($urandom), pick_value()};
      pick = $urandom_range(99);
      if (pick < 12) begin
         rq.opcode = OP_WRITE;
         rq.reg_index = pick_register();
      end else if (pick < 20) begin
         rq.opcode = OP_READ;
         rq.reg_index = pick_register();
      end else if (pick < 24) begin
         // noise: any opcode, any instruction word
         rq.opcode = 2'($urandom_range(0, 3));
      end else if (pick < 62) begin
         shf = ($urandom_range(99) < 10) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
         rq.instruction = imm_insn(1'($urandom), 1'($urandom), 1'($urandom), shf,
                                   12'($urandom), pick_register(), pick_register());
      end else begin
         sf = 1'($urandom);
         shf = ($urandom_range(99) < 8) ? SH_RSV : 2'($urandom_range(0, 2));
         imm6 = (!sf && $urandom_range(99) >= 10) ? 6'($urandom_range(0, 31)) : 6'($urandom);
         rq.instruction = reg_insn(sf, 1'($urandom), 1'($urandom), shf, 1'($urandom),
                                   pick_register(), imm6, pick_register(), pick_register());
      end
      return rq;
   endfunction

   task automatic run_random(int count);
      repeat (count) send_request(random_request());
   endtask

   task automatic report_mismatch(string what, logic [XLEN-1:0] got, logic [XLEN-1:0] want);
      if (mismatch_count < 40) begin
         $display("%0t: response %0d %s got %0h want %0h",
                  $time, responses_checked, what, got, want);
      end
      mismatch_count++;
   endtask

   task automatic test_register_file();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_register(5'd1, '1);
      write_register(5'd2, 64'd1);
      write_register(5'd3, 64'h8000_0000_0000_0000);
      write_register(5'd4, 64'h7fff_ffff_ffff_ffff);
      write_register(REG_ZR, 64'h1000);
      send_request('{OP_SPARE, $urandom, 5'd7, '1});
   endtask

   task automatic test_add_sub_flags();
      run_instruction(reg_insn(1'b1, 1'b0, 1'b1, SH_LSL, 1'b0, 5'd2, 6'd0, 5'd1, 5'd5));
      run_instruction(reg_insn(1'b1, 1'b1, 1'b1, SH_LSL, 1'b0, 5'd2, 6'd0, 5'd3, 5'd6));
      run_instruction(reg_insn(1'b0, 1'b0, 1'b1, SH_LSL, 1'b0, 5'd2, 6'd0, 5'd4, 5'd7));
      // flags held without s
      run_instruction(reg_insn(1'b1, 1'b0, 1'b0, SH_LSL, 1'b0, 5'd2, 6'd0, 5'd4, 5'd8));
      run_instruction(imm_insn(1'b0, 1'b1, 1'b1, 2'd0, 12'hfff, 5'd2, 5'd9));
   endtask

   task automatic test_register31();
      run_instruction(imm_insn(1'b1, 1'b0, 1'b0, 2'd1, 12'hfff, REG_ZR, REG_ZR));
      run_instruction(imm_insn(1'b1, 1'b1, 1'b1, 2'd0, 12'h000, REG_ZR, REG_ZR));
      run_instruction(reg_insn(1'b1, 1'b0, 1'b1, SH_LSL, 1'b0, REG_ZR, 6'd0, REG_ZR, REG_ZR));
      run_instruction(reg_insn(1'b1, 1'b0, 1'b0, SH_LSL, 1'b0, 5'd1, 6'd0, 5'd2, REG_ZR));
      read_register(REG_ZR);
   endtask

   task automatic test_shifts();
      run_instruction(reg_insn(1'b1, 1'b0, 1'b1, SH_ASR, 1'b0, 5'd3, 6'd63, 5'd0, 5'd10));
      run_instruction(reg_insn(1'b0, 1'b0, 1'b0, SH_LSR, 1'b0, 5'd1, 6'd31, 5'd0, 5'd11));
      // extended register bit is ignored
      run_instruction(reg_insn(1'b1, 1'b1, 1'b1, SH_LSL, 1'b1, 5'd4, 6'd1, 5'd1, 5'd12));
      run_instruction(reg_insn(1'b0, 1'b0, 1'b1, SH_ASR, 1'b0, 5'd1, 6'd0, 5'd0, 5'd13));
   endtask

   task automatic test_reserved_encodings();
      run_instruction(imm_insn(1'b1, 1'b0, 1'b1, 2'd2, 12'h123, 5'd1, 5'd14));
      run_instruction(imm_insn(1'b0, 1'b1, 1'b0, 2'd3, 12'hfff, 5'd2, 5'd15));
      run_instruction(reg_insn(1'b1, 1'b0, 1'b1, SH_RSV, 1'b0, 5'd1, 6'd4, 5'd2, 5'd16));
      run_instruction(reg_insn(1'b0, 1'b0, 1'b1, SH_LSL, 1'b0, 5'd1, 6'd32, 5'd2, 5'd17));
      run_instruction('0);
      run_instruction('1);
   endtask

   task automatic test_random_streaming();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      run_random(PHASE_ITEMS);
   endtask

   task automatic test_random_sender_gaps();
      send_idle_pct = 78;
      recv_stall_pct = 0;
      run_random(PHASE_ITEMS);
   endtask

   task automatic test_random_receiver_stalls();
      send_idle_pct = 0;
      recv_stall_pct = 78;
      run_random(PHASE_ITEMS);
   endtask

   task automatic test_random_both_idle();
      send_idle_pct = 28;
      recv_stall_pct = 28;
      run_random(PHASE_ITEMS);
   endtask

   task automatic test_output_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_length = HOLD_CYCLES;
      hold_serial++;
      run_random(30);
   endtask

   // receiver: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_serial != hold_seen) begin
         hold_seen = hold_serial;
         hold_left = hold_length;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("unexpected response", rsp_data.result_data, '0);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
            if (rsp_data.wrote_register !== want.wrote_register)
               report_mismatch("wrote_register", 64'(rsp_data.wrote_register),
                               64'(want.wrote_register));
            if (rsp_data.dest_index !== want.dest_index)
               report_mismatch("dest_index", 64'(rsp_data.dest_index), 64'(want.dest_index));
            if (rsp_data.result_data !== want.result_data)
               report_mismatch("result_data", rsp_data.result_data, want.result_data);
            if (rsp_data.flag_n !== want.flag_n)
               report_mismatch("flag_n", 64'(rsp_data.flag_n), 64'(want.flag_n));
            if (rsp_data.flag_z !== want.flag_z)
               report_mismatch("flag_z", 64'(rsp_data.flag_z), 64'(want.flag_z));
            if (rsp_data.flag_c !== want.flag_c)
               report_mismatch("flag_c", 64'(rsp_data.flag_c), 64'(want.flag_c));
            if (rsp_data.flag_v !== want.flag_v)
               report_mismatch("flag_v", 64'(rsp_data.flag_v), 64'(want.flag_v));
            responses_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, pending_responses.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NUM_REGS; i++) arch_regs[i] = '0;
      arch_nzcv = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_register_file();
      test_add_sub_flags();
      test_register31();
      test_shifts();
      test_reserved_encodings();
      test_random_streaming();
      test_random_sender_gaps();
      test_random_receiver_stalls();
      test_random_both_idle();
      test_output_backpressure();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d requests: %0d add/sub executed, %0d unknown class, %0d reserved shift",
               requests_sent, exec_done, exec_class, exec_shift);
      $display("checked %0d responses under four idle patterns and a %0d-cycle output hold",
               responses_checked, HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
